// ===== rtl/aesps_pkg.sv =====
// Shared types, constants and GF(2^8) helper functions for the AES core.
`default_nettype none
package aesps_pkg;

  localparam int TBL_DEPTH = 256;
  localparam int RK_DEPTH  = 60;
  localparam int RK_AW     = 6;
  localparam int CFG_IDX_W = 3;

  // Key size codes.
  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;
  localparam logic [1:0] MODE_BAD = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd4;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ENC  = 1'b1;

  // Per-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic             tbl_wr;
    logic             load_plain;
    logic             key_wr;
    logic             gen_wr;
    logic             rk_rd;
    logic [RK_AW-1:0] rk_addr;
    logic             tw_load;
    logic             tw_rot;
    logic             use_sub;
    logic             rcon_en;
    logic [3:0]       rc_idx;
    logic             sb_rd;
    logic             sb_state;
    logic [3:0]       sb_idx;
    logic             shift_t;
    logic             shift_s;
    logic             kb_shift;
    logic             st_init;
    logic             st_round;
    logic             mix;
    logic             out_load;
  } dp_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    unique case (idx)
      4'd0:    rcon = 8'h01;
      4'd1:    rcon = 8'h02;
      4'd2:    rcon = 8'h04;
      4'd3:    rcon = 8'h08;
      4'd4:    rcon = 8'h10;
      4'd5:    rcon = 8'h20;
      4'd6:    rcon = 8'h40;
      4'd7:    rcon = 8'h80;
      4'd8:    rcon = 8'h1b;
      default: rcon = 8'h36;
    endcase
  endfunction

  // One column, first byte in the top bits.
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    mix_columns = {mix_col(s[127:96]), mix_col(s[95:64]),
                   mix_col(s[63:32]), mix_col(s[31:0])};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aesps_dp.sv =====
// Datapath: substitution table, round key memory, block state and output register.
`default_nettype none
module aesps_dp
  import aesps_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dp_cmd_t       cmd,
  input  wire logic [7:0]    table_index,
  input  wire logic [7:0]    table_value,
  input  wire logic [63:0]   plain_high,
  input  wire logic [63:0]   plain_low,
  input  wire logic [255:0]  key_flat,
  output logic      [63:0]   cipher_high,
  output logic      [63:0]   cipher_low
);

  logic [7:0]           tbl_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] tbl_vld;
  logic [7:0]           sq_data;
  logic                 sq_vld;
  logic [7:0]           sq_addr;
  logic [7:0]           sq;
  logic [7:0]           sb_addr;

  logic [31:0]          rk_mem [RK_DEPTH];
  logic [31:0]          rkq;

  logic [31:0]          prev;
  logic [31:0]          tw;
  logic [31:0]          tsub;
  logic [31:0]          gen_word;
  logic [31:0]          key_word;
  logic [127:0]         st;
  logic [127:0]         sb;
  logic [127:0]         kb;
  logic [3:0]           src;

  // Entries never loaded read as their own index.
  assign sq = sq_vld ? sq_data : sq_addr;

  // ShiftRows source byte for output byte j: row j[1:0], column j[3:2] + row.
  assign src = {cmd.sb_idx[3:2] + cmd.sb_idx[1:0], cmd.sb_idx[1:0]};

  always_comb begin
    if (cmd.sb_state) begin
      sb_addr = st[8*(15 - int'(src)) +: 8];
    end else begin
      sb_addr = tw[8*(3 - int'(cmd.sb_idx[1:0])) +: 8];
    end
  end

  assign key_word = key_flat[32*(7 - int'(cmd.rk_addr[2:0])) +: 32];
  assign gen_word = rkq ^ (cmd.use_sub ? tsub : tw) ^
                    {(cmd.rcon_en ? rcon(cmd.rc_idx) : 8'h00), 24'h000000};

  // Substitution table valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= '0;
    end else if (cmd.tbl_wr) begin
      tbl_vld[table_index] <= 1'b1;
    end
  end

  // Substitution table storage and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[table_index] <= table_value;
    end
    if (cmd.sb_rd) begin
      sq_data <= tbl_mem[sb_addr];
      sq_vld  <= tbl_vld[sb_addr];
      sq_addr <= sb_addr;
    end
  end

  // Round key memory, one word written or read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      rk_mem[cmd.rk_addr] <= key_word;
    end else if (cmd.gen_wr) begin
      rk_mem[cmd.rk_addr] <= gen_word;
    end
    if (cmd.rk_rd) begin
      rkq <= rk_mem[cmd.rk_addr];
    end
  end

  // Key schedule working words.
  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      prev <= key_word;
    end else if (cmd.gen_wr) begin
      prev <= gen_word;
    end
    if (cmd.tw_load) begin
      tw <= cmd.tw_rot ? {prev[23:0], prev[31:24]} : prev;
    end
    if (cmd.shift_t) begin
      tsub <= {tsub[23:0], sq};
    end
  end

  // Block state, substituted bytes and round key buffer.
  always_ff @(posedge clk) begin
    if (cmd.shift_s) begin
      sb <= {sb[119:0], sq};
    end
    if (cmd.kb_shift) begin
      kb <= {kb[95:0], rkq};
    end
    if (cmd.load_plain) begin
      st <= {plain_high, plain_low};
    end else if (cmd.st_init) begin
      st <= st ^ kb;
    end else if (cmd.st_round) begin
      st <= (cmd.mix ? mix_columns(sb) : sb) ^ kb;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cipher_high <= st[127:64];
      cipher_low  <= st[63:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aesps_ctrl.sv =====
// Controller: sequences key expansion and rounds, and owns the handshakes.
`default_nettype none
module aesps_ctrl
  import aesps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [1:0] mode,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_KLOAD, S_KGEN, S_RND, S_FIN
  } state_t;

  state_t           state;
  logic [4:0]       step;
  logic [RK_AW-1:0] widx;
  logic [2:0]       wmod;
  logic [3:0]       rc;
  logic [3:0]       rnd;

  logic [3:0]       nk;
  logic [3:0]       rounds;
  logic [RK_AW-1:0] last_word;
  logic             accept;
  logic             is_rc;
  logic             need_sub;
  logic [4:0]       kgen_last;
  logic [4:0]       rnd_last;
  logic             free;

  always_comb begin
    unique case (mode)
      MODE_192: nk = 4'd6;
      MODE_256: nk = 4'd8;
      default:  nk = 4'd4;
    endcase
  end

  assign rounds    = nk + 4'd6;
  assign last_word = {rounds, 2'b11};
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_rc     = (wmod == 3'd0);
  assign need_sub  = is_rc || ((mode == MODE_256) && (wmod == 3'd4));
  assign kgen_last = need_sub ? 5'd6 : 5'd1;
  assign rnd_last  = (rnd == 4'd0) ? 5'd5 : 5'd17;
  assign free      = !out_valid || !out_stall;

  // Command decode for the current step.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.tbl_wr     = (kind == KIND_LOAD);
          cmd.load_plain = (kind == KIND_ENC) && (mode != MODE_BAD);
        end
      end
      S_KLOAD: begin
        cmd.key_wr  = 1'b1;
        cmd.rk_addr = widx;
      end
      S_KGEN: begin
        cmd.rc_idx = rc;
        cmd.sb_idx = 4'(step - 5'd1);
        if (step == 5'd0) begin
          cmd.tw_load = 1'b1;
          cmd.tw_rot  = is_rc;
          cmd.rk_rd   = 1'b1;
          cmd.rk_addr = widx - RK_AW'(nk);
        end else if (step == kgen_last) begin
          cmd.gen_wr  = 1'b1;
          cmd.use_sub = need_sub;
          cmd.rcon_en = is_rc;
          cmd.rk_addr = widx;
        end else begin
          cmd.sb_rd   = (step <= 5'd4);
          cmd.shift_t = (step >= 5'd2);
        end
      end
      S_RND: begin
        cmd.rk_addr  = {rnd, step[1:0]};
        cmd.rk_rd    = (step <= 5'd3);
        cmd.kb_shift = (step >= 5'd1) && (step <= 5'd4);
        cmd.sb_state = 1'b1;
        cmd.sb_idx   = step[3:0];
        if (rnd == 4'd0) begin
          cmd.st_init = (step == 5'd5);
        end else begin
          cmd.sb_rd    = (step <= 5'd15);
          cmd.shift_s  = (step >= 5'd1) && (step <= 5'd16);
          cmd.st_round = (step == 5'd17);
          cmd.mix      = (rnd != rounds);
        end
      end
      S_FIN: begin
        cmd.out_load = free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Sequencer state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      widx  <= '0;
      wmod  <= '0;
      rc    <= '0;
      rnd   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (kind == KIND_ENC) && (mode != MODE_BAD)) begin
            state <= S_KLOAD;
            widx  <= '0;
          end
        end
        S_KLOAD: begin
          if (widx == RK_AW'(nk - 4'd1)) begin
            state <= S_KGEN;
            step  <= '0;
            wmod  <= '0;
            rc    <= '0;
          end
          widx <= widx + RK_AW'(1);
        end
        S_KGEN: begin
          if (step == kgen_last) begin
            step <= '0;
            widx <= widx + RK_AW'(1);
            wmod <= (wmod == 3'(nk - 4'd1)) ? 3'd0 : wmod + 3'd1;
            if (is_rc) begin
              rc <= rc + 4'd1;
            end
            if (widx == last_word) begin
              state <= S_RND;
              rnd   <= '0;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        S_RND: begin
          if (step == rnd_last) begin
            step <= '0;
            if (rnd == rounds) begin
              state <= S_FIN;
            end else begin
              rnd <= rnd + 4'd1;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        S_FIN: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result flag of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aes_encrypt_programmable_sbox.sv =====
// AES block encryption with a writable substitution table.
//
// Input channel (in_valid/in_stall): a transfer with kind = 0 writes one
// table entry (table_index, table_value) and gives no result; kind = 1
// encrypts plain_high/plain_low with the configured key. An encrypt
// transfer with key size code 3 is dropped without a result.
// Output channel (out_valid/out_stall) carries cipher_high/cipher_low.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the key
// size and the four key words; it is always ready. It must be written only
// while the block is idle, which the block itself does not enforce.
// Indexes above 4 are ignored. A load item leaves the block idle; an
// encrypt item keeps the input stalled until its result is loaded into
// the output register. The single read port of the substitution table
// serves every byte of the key schedule and of SubBytes one per cycle,
// plus one word a cycle of the round key memory.
// A finished result sits in the output register while the next item is
// taken; if it is still stalled when the next one finishes, that item
// waits in its last state. Reset empties the pipeline, restores the
// identity table, and clears the key size and key words.
`default_nettype none
module aes_encrypt_programmable_sbox
  import aesps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  input  wire logic [7:0]           table_index,
  input  wire logic [7:0]           table_value,
  input  wire logic [63:0]          plain_high,
  input  wire logic [63:0]          plain_low,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [63:0]          cipher_high,
  output logic      [63:0]          cipher_low,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [1:0]  key_size_mode;
  logic [63:0] key_word_0;
  logic [63:0] key_word_1;
  logic [63:0] key_word_2;
  logic [63:0] key_word_3;
  dp_cmd_t     cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_size_mode <= MODE_128;
      key_word_0    <= '0;
      key_word_1    <= '0;
      key_word_2    <= '0;
      key_word_3    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: key_size_mode <= cfg_data[1:0];
        REG_KEY0: key_word_0    <= cfg_data;
        REG_KEY1: key_word_1    <= cfg_data;
        REG_KEY2: key_word_2    <= cfg_data;
        REG_KEY3: key_word_3    <= cfg_data;
        default:  key_size_mode <= key_size_mode;
      endcase
    end
  end

  aesps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .mode      (key_size_mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  aesps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .table_index (table_index),
    .table_value (table_value),
    .plain_high  (plain_high),
    .plain_low   (plain_low),
    .key_flat    ({key_word_0, key_word_1, key_word_2, key_word_3}),
    .cipher_high (cipher_high),
    .cipher_low  (cipher_low)
  );

endmodule
`default_nettype wire
